/* rtl/psp_pkg.sv */
// Package for the printf specifier parser.
// Holds the character constants and the result record type.
// No dependencies.
package psp_pkg;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam int OUT_BITS = 16;

    typedef struct packed {
        logic [OUT_BITS-1:0] text_length;
        logic [7:0]          spec_type;
        logic [OUT_BITS-1:0] field_width;
        logic [OUT_BITS-1:0] precision;
        logic                force_sign;
        logic                zero_pad;
    } psp_rec_t;

endpackage

/* rtl/psp_digit_acc.sv */
// Saturating decimal accumulator: acc * 10 + digit, clipped to all ones.
// Shift-add form, no multiplier. No dependencies.
module psp_digit_acc #(
    parameter int COUNT_BITS = 16
) (
    input  logic [COUNT_BITS-1:0] acc_in,
    input  logic [3:0]            digit,
    output logic [COUNT_BITS-1:0] acc_out
);

    localparam int SUM_W = COUNT_BITS + 4;

    logic [SUM_W-1:0] sum;

    assign sum = {1'b0, acc_in, 3'b000}
               + {3'b000, acc_in, 1'b0}
               + {{COUNT_BITS{1'b0}}, digit};

    assign acc_out = (|sum[SUM_W-1:COUNT_BITS]) ? {COUNT_BITS{1'b1}}
                                                : sum[COUNT_BITS-1:0];

endmodule

/* rtl/psp_step.sv */
// Parse engine: phase register, counters and flags, per-character update.
// Depends on psp_pkg and psp_digit_acc.
module psp_step #(
    parameter int COUNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        char_code,
    output logic              emit,
    output psp_pkg::psp_rec_t rec
);

    localparam logic [2:0] PH_SCAN  = 3'd0;
    localparam logic [2:0] PH_PCT   = 3'd1;
    localparam logic [2:0] PH_FIRST = 3'd2;
    localparam logic [2:0] PH_WIDTH = 3'd3;
    localparam logic [2:0] PH_PREC  = 3'd4;
    localparam int EXT_W = COUNT_BITS + psp_pkg::OUT_BITS;

    logic [2:0]            phase_reg, phase_next;
    logic [COUNT_BITS-1:0] text_count_reg, text_count_next;
    logic [COUNT_BITS-1:0] width_reg, width_next;
    logic [COUNT_BITS-1:0] prec_reg, prec_next;
    logic                  sign_flag_reg, sign_flag_next;
    logic                  zero_flag_reg, zero_flag_next;

    logic [COUNT_BITS-1:0] width_acc;
    logic [COUNT_BITS-1:0] prec_acc;
    logic [3:0]            digit;
    logic                  is_digit;
    logic                  zero_upd;
    logic [7:0]            type_code;
    logic [EXT_W-1:0]      text_ext;
    logic [EXT_W-1:0]      width_ext;
    logic [EXT_W-1:0]      prec_ext;

    assign digit    = 4'(char_code - psp_pkg::CH_ZERO);
    assign is_digit = (char_code >= psp_pkg::CH_ZERO) && (char_code <= psp_pkg::CH_NINE);

    psp_digit_acc #(.COUNT_BITS(COUNT_BITS)) u_width_acc (
        .acc_in  (width_reg),
        .digit   (digit),
        .acc_out (width_acc)
    );

    psp_digit_acc #(.COUNT_BITS(COUNT_BITS)) u_prec_acc (
        .acc_in  (prec_reg),
        .digit   (digit),
        .acc_out (prec_acc)
    );

    always_comb
    begin
        phase_next      = phase_reg;
        text_count_next = text_count_reg;
        width_next      = width_reg;
        prec_next       = prec_reg;
        sign_flag_next  = sign_flag_reg;
        zero_flag_next  = zero_flag_reg;
        zero_upd        = zero_flag_reg;
        emit            = 1'b0;
        type_code       = char_code;
        unique case (phase_reg)
            PH_SCAN:
            begin
                if (char_code == psp_pkg::CH_NUL)
                begin
                    emit = 1'b1;
                end
                else if (char_code == psp_pkg::CH_PERCENT)
                begin
                    phase_next = PH_PCT;
                end
                else if (!(&text_count_reg))
                begin
                    text_count_next = text_count_reg + COUNT_BITS'(1);
                end
            end
            PH_PCT, PH_FIRST, PH_WIDTH:
            begin
                if (phase_reg == PH_PCT && char_code == psp_pkg::CH_PLUS)
                begin
                    sign_flag_next = 1'b1;
                    phase_next     = PH_FIRST;
                end
                else
                begin
                    if (phase_reg != PH_WIDTH)
                    begin
                        zero_upd       = (char_code == psp_pkg::CH_ZERO);
                        zero_flag_next = zero_upd;
                        phase_next     = PH_WIDTH;
                    end
                    if (is_digit)
                    begin
                        width_next = width_acc;
                    end
                    else if (char_code == psp_pkg::CH_DOT)
                    begin
                        phase_next = PH_PREC;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            PH_PREC:
            begin
                if (is_digit)
                begin
                    prec_next = prec_acc;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                phase_next      = PH_SCAN;
                text_count_next = '0;
                width_next      = '0;
                prec_next       = '0;
                sign_flag_next  = 1'b0;
                zero_flag_next  = 1'b0;
            end
        endcase
        if (emit)
        begin
            phase_next      = PH_SCAN;
            text_count_next = '0;
            width_next      = '0;
            prec_next       = '0;
            sign_flag_next  = 1'b0;
            zero_flag_next  = 1'b0;
        end
    end

    // clip counts to the 16-bit result fields
    assign text_ext  = {{psp_pkg::OUT_BITS{1'b0}}, text_count_reg};
    assign width_ext = {{psp_pkg::OUT_BITS{1'b0}}, width_reg};
    assign prec_ext  = {{psp_pkg::OUT_BITS{1'b0}}, prec_reg};

    always_comb
    begin
        rec.text_length = (|text_ext[EXT_W-1:psp_pkg::OUT_BITS]) ? '1
                        : text_ext[psp_pkg::OUT_BITS-1:0];
        rec.field_width = (|width_ext[EXT_W-1:psp_pkg::OUT_BITS]) ? '1
                        : width_ext[psp_pkg::OUT_BITS-1:0];
        rec.precision   = (|prec_ext[EXT_W-1:psp_pkg::OUT_BITS]) ? '1
                        : prec_ext[psp_pkg::OUT_BITS-1:0];
        rec.spec_type   = (phase_reg == PH_SCAN) ? psp_pkg::CH_NUL : type_code;
        rec.force_sign  = sign_flag_reg;
        rec.zero_pad    = zero_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SCAN;
            text_count_reg <= '0;
            width_reg      <= '0;
            prec_reg       <= '0;
            sign_flag_reg  <= 1'b0;
            zero_flag_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            text_count_reg <= text_count_next;
            width_reg      <= width_next;
            prec_reg       <= prec_next;
            sign_flag_reg  <= sign_flag_next;
            zero_flag_reg  <= zero_flag_next;
        end
    end

`ifndef SYNTH
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> phase_reg == PH_SCAN && text_count_reg == '0)
        else $error("engine not cleared after record");

    a_scan_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SCAN |-> !sign_flag_reg && width_reg == '0 && prec_reg == '0)
        else $error("specifier fields set while scanning text");

    a_sign_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sign_flag_reg) |-> phase_reg == PH_FIRST)
        else $error("sign flag set outside the plus position");
`endif

endmodule

/* rtl/printf_spec_parser.sv */
// Top level of the printf specifier parser: input register, parse engine,
// result register. Depends on psp_pkg and psp_step.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+------------------------------------------
//  input   | char_valid | char_stall | char_code
//  result  | spec_valid | spec_stall | text_length spec_type field_width
//          |            |            | precision force_sign zero_pad
//
// One character per cycle unless stalled; a record passes the input and result
// registers in turn. The engine update (compare, times-ten add) sets the rate.
// rst_n clears the phase, counts, flags and both valid registers at once.
// A stalled record holds; characters that give no record keep flowing, and
// one that gives a record waits only while the result register is held.
module printf_spec_parser #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    output logic        spec_valid,
    input  logic        spec_stall,
    output logic [15:0] text_length,
    output logic [7:0]  spec_type,
    output logic [15:0] field_width,
    output logic [15:0] precision,
    output logic        force_sign,
    output logic        zero_pad
);

    logic              char_valid_reg;
    logic [7:0]        char_reg;
    logic              spec_valid_reg, spec_valid_next;
    psp_pkg::psp_rec_t rec_reg;
    psp_pkg::psp_rec_t rec;
    logic              step_fire;
    logic              step_emit;
    logic              slot_free;

    psp_step #(.COUNT_BITS(COUNT_BITS)) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (step_fire),
        .char_code (char_reg),
        .emit      (step_emit),
        .rec       (rec)
    );

    assign slot_free  = !spec_valid_reg || !spec_stall;
    assign step_fire  = char_valid_reg && (!step_emit || slot_free);
    assign char_stall = char_valid_reg && !step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            char_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            char_reg <= char_code;
        end
    end

    always_comb
    begin
        spec_valid_next = spec_valid_reg;
        if (step_fire && step_emit)
        begin
            spec_valid_next = 1'b1;
        end
        else if (!spec_stall)
        begin
            spec_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spec_valid_reg <= 1'b0;
        end
        else
        begin
            spec_valid_reg <= spec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && step_emit)
        begin
            rec_reg <= rec;
        end
    end

    assign spec_valid  = spec_valid_reg;
    assign text_length = rec_reg.text_length;
    assign spec_type   = rec_reg.spec_type;
    assign field_width = rec_reg.field_width;
    assign precision   = rec_reg.precision;
    assign force_sign  = rec_reg.force_sign;
    assign zero_pad    = rec_reg.zero_pad;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        spec_valid_reg && spec_stall |-> !(step_fire && step_emit))
        else $error("held record overwritten");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && step_emit |=> spec_valid)
        else $error("record lost after emit");

    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> char_valid_reg && step_emit && spec_valid_reg)
        else $error("input stalled without a pending record");
`endif

endmodule
